/* design/wsc_pkg.sv */
package wsc_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COUNT_W = 32;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_DESIGN  = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // sequencer controls for one scan cycle
  typedef struct packed {
    logic rd_en;
    logic done;
  } scan_ctrl_t;

endpackage

/* design/wsc_pat_mem.sv */
module wsc_pat_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 68
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/wsc_match.sv */
module wsc_match
  import wsc_pkg::*;
#(
  parameter int unsigned N     = 8,
  parameter int unsigned LEN_W = 4
) (
  input  logic [N-1:0][SYM_W-1:0] pat_syms_i,
  input  logic [LEN_W-1:0]        pat_len_i,
  input  logic [N-1:0][SYM_W-1:0] window_i,
  input  logic [N:0]              reach_i,
  output logic                    hit_o
);

  // pattern of length l ends at the newest symbol and starts at reachable position l-1
  always_comb begin
    logic eq;
    hit_o = 1'b0;
    eq    = 1'b0;
    for (int l = 1; l <= int'(N); l++) begin
      eq = reach_i[l-1];
      for (int j = 0; j < l; j++) begin
        if (pat_syms_i[j] != window_i[l-1-j]) begin
          eq = 1'b0;
        end
      end
      if (pat_len_i == LEN_W'(l)) begin
        hit_o = eq;
      end
    end
  end

endmodule

/* design/word_segmentation_checker_unit.sv */
// word segmentation checker
// input channel (in_valid_i / in_stall_o) carries operation, symbol and last.
// pattern symbols build a pattern; at its last symbol the pattern is stored
// in the table if it fits and there is room, and a status result (kind 1)
// is sent. clear empties the table and the count of segmentable designs, with
// no result. a design symbol shifts the recent-symbol window, then the block
// walks the pattern table one entry per cycle through a single compare unit
// fed by the table memory's read port. a pattern symbol or clear starts no
// walk; in_stall_o is high during a walk. at the last symbol of a design a
// verdict (kind 0) leaves with the running count of segmentable designs, and
// is registered as the walk ends. results sit in an output register
// (out_valid_o / out_stall_i); while the receiver stalls a held result, new
// items are not taken. reset empties the table, clears the count, the pattern
// in progress and the window, and marks the design start reachable; no result
// is pending after it.
module word_segmentation_checker_unit
  import wsc_pkg::*;
#(
  parameter int unsigned MAX_PATTERNS    = 512,
  parameter int unsigned MAX_PATTERN_LEN = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic               segmentable_o,
  output logic [COUNT_W-1:0] valid_count_o,
  output logic [1:0]         status_o
);

  localparam int unsigned N     = MAX_PATTERN_LEN;
  localparam int unsigned LEN_W = $clog2(N + 1);
  localparam int unsigned CNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned AW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned DW    = N * SYM_W + LEN_W;

  state_e state_q, state_d;
  scan_ctrl_t ctrl;

  logic [CNT_W-1:0]        pat_cnt_q, pat_cnt_d;
  logic [N-1:0][SYM_W-1:0] builder_q, builder_d, builder_wr;
  logic [LEN_W-1:0]        blen_q, blen_d, blen_wr;
  logic                    too_long_q, too_long_d, too_long_wr;
  logic [N-1:0][SYM_W-1:0] win_q, win_d;
  logic [N:0]              reach_q, reach_d;
  logic [COUNT_W-1:0]      seg_cnt_q, seg_cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    hit_q, hit_d;
  logic                    dlast_q, dlast_d;

  logic                    out_valid_q, out_valid_d;
  logic                    kind_q, kind_d;
  logic                    seg_q, seg_d;
  logic [COUNT_W-1:0]      vcnt_q, vcnt_d;
  logic [1:0]              status_q, status_d;
  logic                    out_load;

  logic                    accept;
  op_e                     op;
  logic                    mem_we;
  logic [DW-1:0]           mem_rdata;
  logic                    match_hit;

  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op == OP_DESIGN) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ctrl.done) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl = '0;
      end
      S_SCAN: begin
        ctrl.rd_en = (idx_q < pat_cnt_q);
        ctrl.done  = (idx_q >= pat_cnt_q) && !rd_vld_q;
      end
    endcase
  end

  // pattern builder with the incoming symbol appended
  always_comb begin
    builder_wr  = builder_q;
    blen_wr     = blen_q;
    too_long_wr = too_long_q;
    if (blen_q < LEN_W'(N)) begin
      for (int i = 0; i < int'(N); i++) begin
        if (blen_q == LEN_W'(i)) begin
          builder_wr[i] = symbol_i;
        end
      end
      blen_wr = blen_q + LEN_W'(1);
    end else begin
      too_long_wr = 1'b1;
    end
  end

  assign mem_we = accept && op == OP_PATTERN && last_i && !too_long_wr &&
                  (pat_cnt_q < CNT_W'(MAX_PATTERNS));

  always_comb begin
    pat_cnt_d   = pat_cnt_q;
    builder_d   = builder_q;
    blen_d      = blen_q;
    too_long_d  = too_long_q;
    win_d       = win_q;
    reach_d     = reach_q;
    seg_cnt_d   = seg_cnt_q;
    idx_d       = idx_q;
    rd_vld_d    = ctrl.rd_en;
    hit_d       = hit_q;
    dlast_d     = dlast_q;
    out_load    = 1'b0;
    kind_d      = kind_q;
    seg_d       = seg_q;
    vcnt_d      = vcnt_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (accept) begin
      case (op)
        OP_PATTERN: begin
          if (last_i) begin
            builder_d  = '0;
            blen_d     = '0;
            too_long_d = 1'b0;
            if (mem_we) begin
              pat_cnt_d = pat_cnt_q + CNT_W'(1);
            end
            out_load = 1'b1;
            kind_d   = KIND_STATUS;
            seg_d    = 1'b0;
            vcnt_d   = seg_cnt_q;
            if (too_long_wr) begin
              status_d = STATUS_TOO_LONG;
            end else if (!mem_we) begin
              status_d = STATUS_FULL;
            end else begin
              status_d = STATUS_OK;
            end
          end else begin
            builder_d  = builder_wr;
            blen_d     = blen_wr;
            too_long_d = too_long_wr;
          end
        end
        OP_DESIGN: begin
          win_d[0] = symbol_i;
          for (int i = 1; i < int'(N); i++) begin
            win_d[i] = win_q[i-1];
          end
          idx_d    = '0;
          rd_vld_d = 1'b0;
          hit_d    = 1'b0;
          dlast_d  = last_i;
        end
        OP_CLEAR: begin
          pat_cnt_d  = '0;
          seg_cnt_d  = '0;
          builder_d  = '0;
          blen_d     = '0;
          too_long_d = 1'b0;
        end
        default: begin
          pat_cnt_d = pat_cnt_q;
        end
      endcase
    end

    if (ctrl.rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (rd_vld_q) begin
      hit_d = hit_q | match_hit;
    end

    if (ctrl.done) begin
      if (dlast_q) begin
        reach_d   = (N + 1)'(1);
        win_d     = '0;
        seg_cnt_d = seg_cnt_q + COUNT_W'(hit_q);
        out_load  = 1'b1;
        kind_d    = KIND_VERDICT;
        seg_d     = hit_q;
        vcnt_d    = seg_cnt_q + COUNT_W'(hit_q);
        status_d  = STATUS_OK;
      end else begin
        reach_d = {reach_q[N-1:0], hit_q};
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  wsc_pat_mem #(
    .DEPTH(MAX_PATTERNS),
    .AW   (AW),
    .DW   (DW)
  ) u_pat_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(pat_cnt_q[AW-1:0]),
    .wr_data_i({builder_wr, blen_wr}),
    .rd_en_i  (ctrl.rd_en),
    .rd_addr_i(idx_q[AW-1:0]),
    .rd_data_o(mem_rdata)
  );

  wsc_match #(
    .N    (N),
    .LEN_W(LEN_W)
  ) u_match (
    .pat_syms_i(mem_rdata[DW-1:LEN_W]),
    .pat_len_i (mem_rdata[LEN_W-1:0]),
    .window_i  (win_q),
    .reach_i   (reach_q),
    .hit_o     (match_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pat_cnt_q   <= '0;
      builder_q   <= '0;
      blen_q      <= '0;
      too_long_q  <= 1'b0;
      win_q       <= '0;
      reach_q     <= (N + 1)'(1);
      seg_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pat_cnt_q   <= pat_cnt_d;
      builder_q   <= builder_d;
      blen_q      <= blen_d;
      too_long_q  <= too_long_d;
      win_q       <= win_d;
      reach_q     <= reach_d;
      seg_cnt_q   <= seg_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    dlast_q  <= dlast_d;
    kind_q   <= kind_d;
    seg_q    <= seg_d;
    vcnt_q   <= vcnt_d;
    status_q <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign segmentable_o = seg_q;
  assign valid_count_o = vcnt_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_cnt_q <= CNT_W'(MAX_PATTERNS))
    else $error("pattern count beyond table depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= pat_cnt_q)
    else $error("table walk past last stored pattern");

  a_design_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_DESIGN) |=> state_q == S_SCAN)
    else $error("design transfer did not start a table walk");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result loaded over a stalled result");
`endif

endmodule
